// ----- design/i64d_pkg.sv -----
// Package for the pipelined restoring divider.
// Holds the operand width, pipeline latency and the stage control struct.
// Used by every module under design/.
`timescale 1ns / 1ps

package i64d_pkg;

   localparam int WIDTH   = 64;
   // one conditioning stage, WIDTH division cells, one sign-fixup stage
   localparam int LATENCY = WIDTH + 2;

   typedef logic [WIDTH-1:0] word_type;

   typedef struct packed {
      logic valid;
      logic neg_q;
      logic neg_r;
   } ctl_type;

endpackage

// ----- design/i64d_pre.sv -----
// Operand conditioning stage: takes the request and registers the magnitudes.
// Depends on i64d_pkg.
`timescale 1ns / 1ps

module i64d_pre (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  cmd,
   input  i64d_pkg::word_type    dividend,
   input  i64d_pkg::word_type    divisor,
   output i64d_pkg::ctl_type     ctl_o,
   output i64d_pkg::word_type    work_o,
   output i64d_pkg::word_type    den_o
);
   import i64d_pkg::*;

   ctl_type  ctl_ff, ctl_in;
   word_type work_ff, work_in;
   word_type den_ff, den_in;
   logic     a_neg, b_neg;

   always_comb begin
      a_neg        = cmd & dividend[WIDTH-1];
      b_neg        = cmd & divisor[WIDTH-1];
      ctl_in.valid = accept;
      ctl_in.neg_q = a_neg ^ b_neg;
      ctl_in.neg_r = a_neg;
      work_in      = a_neg ? (~dividend + word_type'(1)) : dividend;
      den_in       = b_neg ? (~divisor + word_type'(1)) : divisor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
      end
      work_ff <= work_in;
      den_ff  <= den_in;
   end

   assign ctl_o  = ctl_ff;
   assign work_o = work_ff;
   assign den_o  = den_ff;

endmodule

// ----- design/i64d_cell.sv -----
// One restoring division step: shift one dividend bit into the partial
// remainder, compare-subtract the divisor, shift the quotient bit in.
// Depends on i64d_pkg.
`timescale 1ns / 1ps

module i64d_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  i64d_pkg::ctl_type     ctl_i,
   input  i64d_pkg::word_type    rem_i,
   input  i64d_pkg::word_type    work_i,
   input  i64d_pkg::word_type    den_i,
   output i64d_pkg::ctl_type     ctl_o,
   output i64d_pkg::word_type    rem_o,
   output i64d_pkg::word_type    work_o,
   output i64d_pkg::word_type    den_o
);
   import i64d_pkg::*;

   ctl_type          ctl_ff;
   word_type         rem_ff, rem_in;
   word_type         work_ff, work_in;
   word_type         den_ff;
   logic             carry, take;
   word_type         shifted;
   logic [WIDTH:0]   diff;

   // work holds the unconsumed dividend bits on top, quotient bits below
   always_comb begin
      carry   = rem_i[WIDTH-1];
      shifted = {rem_i[WIDTH-2:0], work_i[WIDTH-1]};
      diff    = {carry, shifted} - {1'b0, den_i};
      take    = carry | ~diff[WIDTH];
      rem_in  = take ? diff[WIDTH-1:0] : shifted;
      work_in = {work_i[WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff <= ctl_i;
      end
      rem_ff  <= rem_in;
      work_ff <= work_in;
      den_ff  <= den_i;
   end

   assign ctl_o  = ctl_ff;
   assign rem_o  = rem_ff;
   assign work_o = work_ff;
   assign den_o  = den_ff;

endmodule

// ----- design/i64d_post.sv -----
// Sign fixup stage: negates quotient and remainder as the operand signs ask
// and registers the result strobe. Depends on i64d_pkg.
`timescale 1ns / 1ps

module i64d_post (
   input  logic                  clock,
   input  logic                  reset,
   input  i64d_pkg::ctl_type     ctl_i,
   input  i64d_pkg::word_type    rem_i,
   input  i64d_pkg::word_type    quo_i,
   output logic                  valid_o,
   output i64d_pkg::word_type    quotient_o,
   output i64d_pkg::word_type    remainder_o
);
   import i64d_pkg::*;

   logic     valid_ff;
   word_type quo_ff, quo_in;
   word_type rem_ff, rem_in;

   always_comb begin
      quo_in = ctl_i.neg_q ? (~quo_i + word_type'(1)) : quo_i;
      rem_in = ctl_i.neg_r ? (~rem_i + word_type'(1)) : rem_i;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= ctl_i.valid;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign valid_o     = valid_ff;
   assign quotient_o  = quo_ff;
   assign remainder_o = rem_ff;

endmodule

// ----- design/int64_divider.sv -----
// Top level of the pipelined signed/unsigned restoring divider.
// Depends on i64d_pkg, i64d_pre, i64d_cell and i64d_post.
//
//   channel   | handshake          | payload
//   ----------+--------------------+------------------------------------------
//   request   | start, busy        | req_cmd, req_dividend, req_divisor
//   response  | rsp_valid (strobe) | rsp_quotient, rsp_remainder
//
// A transfer is taken on every cycle with start high and busy low: one per
// clock. Its result is strobed after it has passed through the registers of
// the conditioning stage, the row of 64 compare-subtract cells and the sign
// stage, in that order.
// busy is reset delayed by one register; reset flushes the pipe.
// The receiver cannot stall, so rsp_valid is a single-cycle strobe.
`timescale 1ns / 1ps

module int64_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_cmd,
   input  i64d_pkg::word_type    req_dividend,
   input  i64d_pkg::word_type    req_divisor,
   output logic                  rsp_valid,
   output i64d_pkg::word_type    rsp_quotient,
   output i64d_pkg::word_type    rsp_remainder
);
   import i64d_pkg::*;

   logic     busy_ff;
   logic     accept;
   ctl_type  ctl_s  [0:WIDTH];
   word_type rem_s  [0:WIDTH];
   word_type work_s [0:WIDTH];
   word_type den_s  [0:WIDTH];

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   i64d_pre u_pre (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .cmd      (req_cmd),
      .dividend (req_dividend),
      .divisor  (req_divisor),
      .ctl_o    (ctl_s[0]),
      .work_o   (work_s[0]),
      .den_o    (den_s[0])
   );

   // partial remainder starts at zero
   assign rem_s[0] = '0;

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      i64d_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl_i  (ctl_s[i]),
         .rem_i  (rem_s[i]),
         .work_i (work_s[i]),
         .den_i  (den_s[i]),
         .ctl_o  (ctl_s[i+1]),
         .rem_o  (rem_s[i+1]),
         .work_o (work_s[i+1]),
         .den_o  (den_s[i+1])
      );
   end

   i64d_post u_post (
      .clock       (clock),
      .reset       (reset),
      .ctl_i       (ctl_s[WIDTH]),
      .rem_i       (rem_s[WIDTH]),
      .quo_i       (work_s[WIDTH]),
      .valid_o     (rsp_valid),
      .quotient_o  (rsp_quotient),
      .remainder_o (rsp_remainder)
   );

endmodule

// ----- design/i64d_checker.sv -----
// Port-level checks for int64_divider, attached by the bind at the end.
// Depends on i64d_pkg.
`timescale 1ns / 1ps

module i64d_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  req_cmd,
   input i64d_pkg::word_type    req_dividend,
   input i64d_pkg::word_type    req_divisor,
   input logic                  rsp_valid,
   input i64d_pkg::word_type    rsp_quotient,
   input i64d_pkg::word_type    rsp_remainder
);
   import i64d_pkg::*;

   // every accepted transfer produces a strobe after the fixed latency
   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("missing result after accepted transfer");

   // no strobe without a matching transfer
   a_latency_back : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a request");

   // unsigned divide by zero: all ones, dividend returned
   a_div_zero : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_cmd && req_divisor == '0) |-> ##LATENCY
      (rsp_quotient == '1 && rsp_remainder == $past(req_dividend, LATENCY)))
      else $error("unsigned divide by zero result wrong");

   // unsigned divide by one: dividend back, no remainder
   a_div_one : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_cmd && req_divisor == word_type'(1)) |-> ##LATENCY
      (rsp_quotient == $past(req_dividend, LATENCY) && rsp_remainder == '0))
      else $error("unsigned divide by one result wrong");

endmodule

bind int64_divider i64d_checker u_chk (.*);
